// ===== sv/tsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types and constants for the three-channel square tone generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

    // Command codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_LATCH = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Register file layout
    localparam int unsigned REG_COUNT   = 14;
    localparam int unsigned MIXER_REG   = 7;
    localparam int unsigned VOLUME_BASE = 8;

    // Field and state widths
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned REGNUM_W = 4;
    localparam int unsigned CNT_W    = 18;
    localparam int unsigned PERIOD_W = 12;
    localparam int unsigned VOL_W    = 4;
    localparam int unsigned AMP_W    = 11;
    localparam int unsigned SAMPLE_W = 13;
    localparam int unsigned OUT_W    = 16;

    typedef logic [DATA_W-1:0]   byte_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [AMP_W-1:0]    amp_t;
    typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

// ===== sv/three_channel_square_tone_generator.sv =====
// ----------------------------------------------------------------------------
// three_channel_square_tone_generator
// Register-addressed square-wave tone block with up to three channels.
// ----------------------------------------------------------------------------
// Each input item is a command in tuser and a byte in tdata: latch a register
// number, write a byte to the latched register (numbers 14 and 15 are dropped),
// or tick. Latch and write items give no result; a tick gives one 13-bit
// sample, the sum of every enabled channel's amplitude (volume * 96 while its
// level is high), and advances each enabled channel's down counter, toggling
// the level and reloading (period + 1) * 16 when the count runs out. Register
// 7 bit c disables channel c; registers 2c/2c+1 hold its 12-bit period and
// register 8+c its 4-bit volume. All channel updates are done in the accepting
// cycle and the sample lands in the output register, so an item is taken every
// cycle while the output side keeps up.
// ----------------------------------------------------------------------------
module three_channel_square_tone_generator #(
    parameter int unsigned CHANNELS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [12:0] sample, [15:13] zero
);

    // Register file and latched register number
    tsg_pkg::byte_t                        regs_reg [tsg_pkg::REG_COUNT];
    logic [tsg_pkg::REGNUM_W-1:0]          regnum_reg;

    // Channel state
    tsg_pkg::cnt_t                         cnt_reg   [CHANNELS];
    tsg_pkg::cnt_t                         cnt_next  [CHANNELS];
    logic [CHANNELS-1:0]                   level_reg;
    logic [CHANNELS-1:0]                   level_next;
    tsg_pkg::amp_t                         amp       [CHANNELS];
    logic [CHANNELS-1:0]                   enabled;

    // Output register
    logic                                  out_valid_reg;
    tsg_pkg::sample_t                      sample_reg;
    tsg_pkg::sample_t                      sample_next;

    logic                                  accept;
    logic                                  is_latch;
    logic                                  is_write;
    logic                                  is_tick;
    tsg_pkg::cmd_t                         cmd;

    // Take an item whenever the output register is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = tsg_pkg::cmd_t'(s_tuser);
    assign is_latch = accept && (cmd == tsg_pkg::CMD_LATCH);
    assign is_write = accept && (cmd == tsg_pkg::CMD_WRITE);
    assign is_tick  = accept && (cmd == tsg_pkg::CMD_TICK);

    // Latch the register number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regnum_reg <= '0;
        end
        else if (is_latch)
        begin
            regnum_reg <= s_tdata[tsg_pkg::REGNUM_W-1:0];
        end
    end

    // Store data into the addressed sound register; numbers past the file drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < tsg_pkg::REG_COUNT; e++)
            begin
                regs_reg[e] <= '0;
            end
        end
        else if (is_write)
        begin
            for (int e = 0; e < tsg_pkg::REG_COUNT; e++)
            begin
                if (regnum_reg == tsg_pkg::REGNUM_W'(e))
                begin
                    regs_reg[e] <= s_tdata;
                end
            end
        end
    end

    // Per-channel tone logic
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        localparam int unsigned LoIdx  = 2 * c;
        localparam int unsigned HiIdx  = 2 * c + 1;
        localparam int unsigned VolIdx = tsg_pkg::VOLUME_BASE + c;

        logic [tsg_pkg::PERIOD_W-1:0] period;
        logic [tsg_pkg::PERIOD_W:0]   period_inc;
        logic [tsg_pkg::VOL_W-1:0]    vol;
        tsg_pkg::cnt_t                reload;

        assign enabled[c]  = !regs_reg[tsg_pkg::MIXER_REG][c];
        assign period      = {regs_reg[HiIdx][3:0], regs_reg[LoIdx]};
        assign period_inc  = {1'b0, period} + 13'd1;
        assign reload      = {1'b0, period_inc, 4'b0000};
        assign vol         = regs_reg[VolIdx][tsg_pkg::VOL_W-1:0];

        // Amplitude is volume * 96 while the level is high
        assign amp[c] = (enabled[c] && level_reg[c])
                      ? ({1'b0, vol, 6'b0} + {2'b0, vol, 5'b0})
                      : '0;

        // Count down; toggle and reload once the count runs out
        always_comb
        begin
            if (cnt_reg[c] <= tsg_pkg::CNT_W'(1))
            begin
                level_next[c] = !level_reg[c];
                cnt_next[c]   = reload;
            end
            else
            begin
                level_next[c] = level_reg[c];
                cnt_next[c]   = cnt_reg[c] - tsg_pkg::CNT_W'(1);
            end
        end

        // Advance only on a tick with the channel enabled
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[c]   <= '0;
                level_reg[c] <= 1'b0;
            end
            else if (is_tick && enabled[c])
            begin
                cnt_reg[c]   <= cnt_next[c];
                level_reg[c] <= level_next[c];
            end
        end
    end

    // Sum the channel amplitudes
    always_comb
    begin
        sample_next = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            sample_next = sample_next + tsg_pkg::SAMPLE_W'(amp[c]);
        end
    end

    // Hold the result until the output side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (is_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_tick)
        begin
            sample_reg <= sample_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tsg_pkg::OUT_W - tsg_pkg::SAMPLE_W){1'b0}}, sample_reg};

endmodule
